// File: hdl/isv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isv_pkg
// Types, character codes and small modulo helpers for the ISBN validator.
// ----------------------------------------------------------------------------
package isv_pkg;

    localparam logic [7:0] C_ASCII_0  = 8'h30;
    localparam logic [7:0] C_ASCII_9  = 8'h39;
    localparam logic [7:0] C_ASCII_UX = 8'h58;
    localparam logic [7:0] C_ASCII_LX = 8'h78;

    localparam logic [3:0] C_VALUE_X      = 4'd10;
    localparam logic [3:0] C_MAX_KEPT     = 4'd14;
    localparam logic [3:0] C_LEN_ISBN10   = 4'd10;
    localparam logic [3:0] C_LEN_ISBN13   = 4'd13;
    localparam logic [3:0] C_POS_CHECK10  = 4'd9;
    localparam logic [3:0] C_POS_CHECK13  = 4'd12;
    localparam logic [3:0] C_PREFIX_LEN   = 4'd3;
    localparam logic [3:0] C_MID_LAST     = 4'd11;
    localparam logic [3:0] C_SUM13_PREFIX = 4'd8;

    localparam int C_MOD11   = 11;
    localparam int C_MOD10   = 10;
    localparam int C_RECIP11 = 187;  // ceil(2^11 / 11)
    localparam int C_RECIP10 = 205;  // ceil(2^11 / 10)

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_ISBN10 = 2'd1,
        KIND_ISBN13 = 2'd2
    } t_kind;

    typedef struct packed {
        logic [3:0] kept_count;
        logic [3:0] sum_ten;
        logic [3:0] sum_thirteen;
        logic [3:0] sum_to_ten;
        logic [3:0] sum_to_thirteen;
        logic [3:0] tenth_char;
        logic [3:0] thirteenth_digit;
        logic       prefix_match;
        logic       misplaced_x;
    } t_isv_state;

    typedef struct packed {
        t_kind      kind;
        logic       valid_res;
        logic [3:0] expected_check;
        logic       convert_ok;
        logic [3:0] converted_check;
    } t_isv_result;

    localparam t_isv_state C_STATE_RESET = '{
        kept_count:       4'd0,
        sum_ten:          4'd0,
        sum_thirteen:     4'd0,
        sum_to_ten:       4'd0,
        sum_to_thirteen:  C_SUM13_PREFIX,
        tenth_char:       4'd0,
        thirteenth_digit: 4'd0,
        prefix_match:     1'b1,
        misplaced_x:      1'b0
    };

    // Remainder by eleven through a reciprocal multiply; exact for all 7-bit inputs.
    function automatic logic [3:0] mod11(input logic [6:0] x);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [6:0]  r;
        prod = 15'(x) * 15'(C_RECIP11);
        q    = prod[14:11];
        r    = x - 7'(q) * 7'(C_MOD11);
        return r[3:0];
    endfunction

    function automatic logic [3:0] mod10(input logic [6:0] x);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [6:0]  r;
        prod = 15'(x) * 15'(C_RECIP10);
        q    = prod[14:11];
        r    = x - 7'(q) * 7'(C_MOD10);
        return r[3:0];
    endfunction

    function automatic logic [3:0] check11(input logic [3:0] s);
        return (s == 4'd0) ? 4'd0 : 4'(C_MOD11) - s;
    endfunction

    function automatic logic [3:0] check10(input logic [3:0] s);
        return (s == 4'd0) ? 4'd0 : 4'(C_MOD10) - s;
    endfunction

    function automatic logic [3:0] prefix_digit(input logic [1:0] p);
        logic [3:0] d;
        case (p)
            2'd0:    d = 4'd9;
            2'd1:    d = 4'd7;
            2'd2:    d = 4'd8;
            default: d = 4'd0;
        endcase
        return d;
    endfunction

endpackage

// File: hdl/isv_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isv_step
// Absorbs one character into the running sums and forms the result that a
// final character produces.
// ----------------------------------------------------------------------------
module isv_step (
    input  isv_pkg::t_isv_state  i_state,
    input  logic [7:0]           i_ch,
    input  logic                 i_last,
    output isv_pkg::t_isv_state  o_next,
    output isv_pkg::t_isv_result o_result
);
    import isv_pkg::*;

    logic       w_kept;
    logic       w_is_x;
    logic       w_take;
    logic [3:0] w_v;
    logic [3:0] w_p;
    logic [3:0] w_wt_ten;
    logic [3:0] w_wt_13;
    logic [3:0] w_wt_to10;
    logic [3:0] w_wt_to13;
    t_isv_state w_upd;

    always_comb begin
        w_is_x = (i_ch == C_ASCII_UX) || (i_ch == C_ASCII_LX);
        w_kept = (i_ch inside {[C_ASCII_0:C_ASCII_9]}) || w_is_x;
        w_v    = w_is_x ? C_VALUE_X : 4'(i_ch - C_ASCII_0);
        w_p    = i_state.kept_count;
        w_take = w_kept && (w_p < C_MAX_KEPT);

        w_wt_ten  = 4'd10 - w_p;
        w_wt_to10 = 4'd13 - w_p;
        w_wt_13   = w_p[0] ? 4'd3 : 4'd1;
        w_wt_to13 = w_p[0] ? 4'd1 : 4'd3;

        w_upd = i_state;
        if (w_take) begin
            w_upd.kept_count = w_p + 4'd1;
            if (w_p < C_POS_CHECK10) begin
                w_upd.sum_ten = mod11(7'(i_state.sum_ten) + 7'(w_wt_ten) * 7'(w_v));
                w_upd.sum_to_thirteen =
                    mod10(7'(i_state.sum_to_thirteen) + 7'(w_wt_to13) * 7'(w_v));
            end
            if (w_p < C_POS_CHECK13) begin
                w_upd.sum_thirteen =
                    mod10(7'(i_state.sum_thirteen) + 7'(w_wt_13) * 7'(w_v));
            end
            if ((w_p >= C_PREFIX_LEN) && (w_p <= C_MID_LAST)) begin
                w_upd.sum_to_ten = mod11(7'(i_state.sum_to_ten) + 7'(w_wt_to10) * 7'(w_v));
            end
            if ((w_p < C_PREFIX_LEN) && (w_v != prefix_digit(w_p[1:0]))) begin
                w_upd.prefix_match = 1'b0;
            end
            if (w_p == C_POS_CHECK10) begin
                w_upd.tenth_char = w_v;
            end
            if (w_p == C_POS_CHECK13) begin
                w_upd.thirteenth_digit = w_v;
            end
            if (w_is_x && (w_p != C_POS_CHECK10)) begin
                w_upd.misplaced_x = 1'b1;
            end
        end
    end

    // Result over the state that includes this character.
    always_comb begin
        o_result = '{kind: KIND_NONE, valid_res: 1'b0, expected_check: 4'd0,
                     convert_ok: 1'b0, converted_check: 4'd0};
        if (w_upd.kept_count == C_LEN_ISBN10) begin
            o_result.kind           = KIND_ISBN10;
            o_result.expected_check = check11(w_upd.sum_ten);
            o_result.valid_res      = !w_upd.misplaced_x &&
                                      (w_upd.tenth_char == check11(w_upd.sum_ten));
            o_result.convert_ok     = o_result.valid_res;
            if (o_result.valid_res) begin
                o_result.converted_check = check10(w_upd.sum_to_thirteen);
            end
        end else if (w_upd.kept_count == C_LEN_ISBN13) begin
            o_result.kind           = KIND_ISBN13;
            o_result.expected_check = check10(w_upd.sum_thirteen);
            o_result.valid_res      = !w_upd.misplaced_x && (w_upd.tenth_char != C_VALUE_X) &&
                                      (w_upd.thirteenth_digit == check10(w_upd.sum_thirteen));
            o_result.convert_ok     = o_result.valid_res && w_upd.prefix_match;
            if (o_result.convert_ok) begin
                o_result.converted_check = check11(w_upd.sum_to_ten);
            end
        end
    end

    // A final character ends the text, so the sums start afresh.
    assign o_next = i_last ? C_STATE_RESET : w_upd;

endmodule

// File: hdl/isbn_stream_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isbn_stream_validator
// ISBN-10 / ISBN-13 check digit validation with conversion, fed one
// character per beat.
//
//   channel | handshake                 | payload
//   --------+---------------------------+-----------------------------------
//   input   | i_in_valid / o_in_ready   | i_ch, i_last
//   output  | o_out_valid / i_out_ready | o_kind, o_valid_res,
//           |                           | o_expected_check, o_convert_ok,
//           |                           | o_converted_check
//
// One character is taken every cycle while no last beat stalls; the beat
// marked last is held in the input register, and its result then in the
// result register. Reset clears the running sums and both registers' valid
// flags. A last beat waits in the input register while the result register
// is still full, which is the only stall; other beats pass regardless.
// ----------------------------------------------------------------------------
module isbn_stream_validator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_kind,
    output logic       o_valid_res,
    output logic [3:0] o_expected_check,
    output logic       o_convert_ok,
    output logic [3:0] o_converted_check
);
    import isv_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_ch;
    logic        r_last;
    t_isv_state  r_state;
    t_isv_state  n_state;
    logic        r_out_valid;
    t_isv_result r_res;
    t_isv_result n_res;
    logic        w_advance;

    // A beat without a result never needs the result register.
    assign w_advance  = r_in_valid && (!r_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    isv_step u_step (
        .i_state  (r_state),
        .i_ch     (r_ch),
        .i_last   (r_last),
        .o_next   (n_state),
        .o_result (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_ch   <= i_ch;
            r_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_STATE_RESET;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_last) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_res.kind;
    assign o_valid_res       = r_res.valid_res;
    assign o_expected_check  = r_res.expected_check;
    assign o_convert_ok      = r_res.convert_ok;
    assign o_converted_check = r_res.converted_check;

    // A final beat leaves the accumulators at their reset values.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_last) |=> (r_state == C_STATE_RESET))
        else $error("state not restarted after final beat");

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.kept_count <= C_MAX_KEPT)
        else $error("kept count beyond saturation");

    a_conv_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.convert_ok) |-> r_res.valid_res)
        else $error("conversion flagged on invalid text");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.kind == KIND_NONE)) |->
        (!r_res.valid_res && (r_res.expected_check == 4'd0) &&
         (r_res.converted_check == 4'd0)))
        else $error("non-empty fields for unrecognised length");

    a_check_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_res.expected_check <= C_VALUE_X) &&
                         (r_res.converted_check <= C_VALUE_X)))
        else $error("check digit out of range");

endmodule
